// File: hw/rtl/depth_to_point_cloud_unit_defines.svh
// Assertion macros shared by the depth to point cloud RTL.
`ifndef DEPTH_TO_POINT_CLOUD_UNIT_DEFINES_SVH
`define DEPTH_TO_POINT_CLOUD_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define DPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define DPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define DPC_ASSERT_SAME(label, clk, rst, ante, cons)
`define DPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/dpc_pkg.sv
// Shared types and constants of the depth to point cloud unit.
package dpc_pkg;

   localparam int DEPTH_W      = 16;
   localparam int COLOR_W      = 8;
   localparam int COORD_W      = 32;
   localparam int INV_W        = 24;
   localparam int CENTER_W     = 16;
   localparam int DIM_W        = 13;
   localparam int FRAC_W       = 24;
   localparam int SUBPIX_SHIFT = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;

   // Saturation limits of a signed 32-bit coordinate.
   localparam logic [COORD_W-1:0] COORD_MAX     = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_NEG_MAG = 32'h8000_0000;

   // Register values after reset.
   localparam logic [INV_W-1:0]    INV_FX_RESET       = 24'd31957;
   localparam logic [INV_W-1:0]    INV_FY_RESET       = 24'd31957;
   localparam logic [CENTER_W-1:0] CX_Q4_RESET        = 16'd5112;
   localparam logic [CENTER_W-1:0] CY_Q4_RESET        = 16'd3832;
   localparam logic [DIM_W-1:0]    FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RESET = 13'd480;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INV_FX       = 3'd0,
      CSR_INV_FY       = 3'd1,
      CSR_CX_Q4        = 3'd2,
      CSR_CY_Q4        = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5
   } csr_reg_type;

   // One pixel of the input stream.
   typedef struct packed {
      logic [DEPTH_W-1:0] depth_mm;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic               frame_start;
   } req_payload_type;

   // One point of the result stream.
   typedef struct packed {
      logic signed [COORD_W-1:0] x_q4;
      logic signed [COORD_W-1:0] y_q4;
      logic [DEPTH_W-1:0]        z_mm;
      logic                      point_valid;
      logic [COLOR_W-1:0]        out_blue;
      logic [COLOR_W-1:0]        out_green;
      logic [COLOR_W-1:0]        out_red;
      logic                      end_of_frame;
   } rsp_payload_type;

endpackage

// File: hw/rtl/dpc_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface dpc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/depth_to_point_cloud_unit.sv
// Depth to point cloud unit: pinhole back-projection of a raster depth stream.
//
// req_stream carries one pixel per transfer (depth in mm, BGR color, frame
// start flag) in raster order; rsp_stream carries one 3D point per pixel in
// the same order. Column and row are tracked inside; frame_start forces the
// pixel to column 0, row 0. The csr_ port writes camera intrinsics and frame size;
// the user must write only while the unit holds no pixel in flight (unchecked).
//
// A point reaches rsp_stream through a five-register pipeline (input register,
// offset-times-reciprocal multiply, two half products times depth, product sum,
// rounding and saturation into the output register). Throughput: one pixel per
// cycle while the receiver does not stall.
//
// Reset clears the counters, the pipeline valid bits and loads the default
// intrinsics (640 x 480 frame). When the receiver stalls, points back up in
// the pipeline registers; req_stream.ready drops only once all five hold a
// point, so no pixel is lost or repeated.
`include "depth_to_point_cloud_unit_defines.svh"

module depth_to_point_cloud_unit import dpc_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   dpc_stream_if.sink             req_stream,
   dpc_stream_if.source           rsp_stream,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W     = $clog2(MAX_DIM);
   localparam int DIM_CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
   localparam int POS_W     = CNT_W + SUBPIX_SHIFT;
   localparam int DIFF_W    = (POS_W > CENTER_W) ? POS_W : CENTER_W;
   localparam int PROD_W    = DIFF_W + INV_W;
   localparam int LO_W      = (PROD_W + 1) / 2;
   localparam int HI_W      = PROD_W - LO_W;
   localparam int MAG_W     = PROD_W + DEPTH_W;
   localparam int QUO_W     = MAG_W - FRAC_W + 1;

   typedef struct packed {
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic               end_of_frame;
   } side_type;

   typedef struct packed {
      logic [DIFF_W-1:0]  diff_x;
      logic               neg_x;
      logic [DIFF_W-1:0]  diff_y;
      logic               neg_y;
      logic [DEPTH_W-1:0] depth;
      side_type           side;
   } s1_type;

   typedef struct packed {
      logic [PROD_W-1:0]  prod_x;
      logic               neg_x;
      logic [PROD_W-1:0]  prod_y;
      logic               neg_y;
      logic [DEPTH_W-1:0] depth;
      side_type           side;
   } s2_type;

   typedef struct packed {
      logic [LO_W+DEPTH_W-1:0] lo_x;
      logic [HI_W+DEPTH_W-1:0] hi_x;
      logic                    neg_x;
      logic [LO_W+DEPTH_W-1:0] lo_y;
      logic [HI_W+DEPTH_W-1:0] hi_y;
      logic                    neg_y;
      logic [DEPTH_W-1:0]      depth;
      side_type                side;
   } s3_type;

   typedef struct packed {
      logic [MAG_W-1:0]   mag_x;
      logic               neg_x;
      logic [MAG_W-1:0]   mag_y;
      logic               neg_y;
      logic [DEPTH_W-1:0] depth;
      side_type           side;
   } s4_type;

   // Floor of a signed magnitude over 2^24, saturated to 32 bits.
   function automatic logic [COORD_W-1:0] round_sat(input logic [MAG_W-1:0] mag,
                                                    input logic neg);
      logic [QUO_W-1:0]   quo;
      logic [QUO_W-1:0]   quo_up;
      logic [QUO_W-1:0]   neg_quo;
      logic [COORD_W-1:0] res;
      quo     = QUO_W'(mag >> FRAC_W);
      quo_up  = quo + QUO_W'(|mag[FRAC_W-1:0]);
      neg_quo = '0 - quo_up;
      if (!neg) begin
         res = (quo > QUO_W'(COORD_MAX)) ? COORD_MAX : quo[COORD_W-1:0];
      end else begin
         res = (quo_up > QUO_W'(COORD_NEG_MAG)) ? COORD_NEG_MAG : neg_quo[COORD_W-1:0];
      end
      return res;
   endfunction

   // Configuration registers.
   logic [INV_W-1:0]    inv_fx_ff;
   logic [INV_W-1:0]    inv_fy_ff;
   logic [CENTER_W-1:0] cx_q4_ff;
   logic [CENTER_W-1:0] cy_q4_ff;
   logic [DIM_W-1:0]    frame_width_ff;
   logic [DIM_W-1:0]    frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_fx_ff       <= INV_FX_RESET;
         inv_fy_ff       <= INV_FY_RESET;
         cx_q4_ff        <= CX_Q4_RESET;
         cy_q4_ff        <= CY_Q4_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INV_FX:       inv_fx_ff       <= csr_wdata[INV_W-1:0];
            CSR_INV_FY:       inv_fy_ff       <= csr_wdata[INV_W-1:0];
            CSR_CX_Q4:        cx_q4_ff        <= csr_wdata[CENTER_W-1:0];
            CSR_CY_Q4:        cy_q4_ff        <= csr_wdata[CENTER_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline handshake: a stage moves on when it is empty or its successor moves.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
   logic req_xfer;

   assign adv_s5 = !s5_valid_ff || rsp_stream.ready;
   assign adv_s4 = !s4_valid_ff || adv_s5;
   assign adv_s3 = !s3_valid_ff || adv_s4;
   assign adv_s2 = !s2_valid_ff || adv_s3;
   assign adv_s1 = !s1_valid_ff || adv_s2;

   assign req_stream.ready = adv_s1;
   assign req_xfer         = req_stream.valid && adv_s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv_s1) s1_valid_ff <= req_stream.valid;
         if (adv_s2) s2_valid_ff <= s1_valid_ff;
         if (adv_s3) s3_valid_ff <= s2_valid_ff;
         if (adv_s4) s4_valid_ff <= s3_valid_ff;
         if (adv_s5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Position of the incoming pixel and the frame size limits.
   logic [CNT_W-1:0]     column_count_ff, column_count_in;
   logic [CNT_W-1:0]     row_count_ff, row_count_in;
   logic [CNT_W-1:0]     col_cur, row_cur;
   logic [DIM_CMP_W-1:0] width_raw, height_raw, width_lim, height_lim;
   logic                 last_col, last_row;

   always_comb begin
      width_raw  = DIM_CMP_W'(frame_width_ff);
      height_raw = DIM_CMP_W'(frame_height_ff);
      if (width_raw == '0) width_lim = DIM_CMP_W'(1);
      else if (width_raw > DIM_CMP_W'(MAX_DIM)) width_lim = DIM_CMP_W'(MAX_DIM);
      else width_lim = width_raw;
      if (height_raw == '0) height_lim = DIM_CMP_W'(1);
      else if (height_raw > DIM_CMP_W'(MAX_DIM)) height_lim = DIM_CMP_W'(MAX_DIM);
      else height_lim = height_raw;

      col_cur  = req_stream.payload.frame_start ? '0 : column_count_ff;
      row_cur  = req_stream.payload.frame_start ? '0 : row_count_ff;
      last_col = (DIM_CMP_W'(col_cur) + DIM_CMP_W'(1)) >= width_lim;
      last_row = (DIM_CMP_W'(row_cur) + DIM_CMP_W'(1)) >= height_lim;
   end

   // Raster counters advance once per accepted pixel.
   always_comb begin
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : row_cur + CNT_W'(1);
      end else begin
         column_count_in = col_cur + CNT_W'(1);
         row_count_in    = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (req_xfer) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Stage 1: signed offset of the pixel from the principal point.
   s1_type s1_ff, s1_in;
   logic [DIFF_W-1:0] pos_x, pos_y, ctr_x, ctr_y;

   always_comb begin
      pos_x = DIFF_W'(col_cur) << SUBPIX_SHIFT;
      pos_y = DIFF_W'(row_cur) << SUBPIX_SHIFT;
      ctr_x = DIFF_W'(cx_q4_ff);
      ctr_y = DIFF_W'(cy_q4_ff);
      s1_in.neg_x             = pos_x < ctr_x;
      s1_in.diff_x            = s1_in.neg_x ? ctr_x - pos_x : pos_x - ctr_x;
      s1_in.neg_y             = pos_y < ctr_y;
      s1_in.diff_y            = s1_in.neg_y ? ctr_y - pos_y : pos_y - ctr_y;
      s1_in.depth             = req_stream.payload.depth_mm;
      s1_in.side.blue         = req_stream.payload.blue;
      s1_in.side.green        = req_stream.payload.green;
      s1_in.side.red          = req_stream.payload.red;
      s1_in.side.end_of_frame = last_col && last_row;
   end

   // Stage 2: offset times the focal reciprocal.
   s2_type s2_ff, s2_in;

   always_comb begin
      s2_in.prod_x = PROD_W'(s1_ff.diff_x) * PROD_W'(inv_fx_ff);
      s2_in.prod_y = PROD_W'(s1_ff.diff_y) * PROD_W'(inv_fy_ff);
      s2_in.neg_x  = s1_ff.neg_x;
      s2_in.neg_y  = s1_ff.neg_y;
      s2_in.depth  = s1_ff.depth;
      s2_in.side   = s1_ff.side;
   end

   // Stage 3: both halves of the product times the depth.
   s3_type s3_ff, s3_in;

   always_comb begin
      s3_in.lo_x  = (LO_W + DEPTH_W)'(s2_ff.prod_x[LO_W-1:0]) *
                    (LO_W + DEPTH_W)'(s2_ff.depth);
      s3_in.hi_x  = (HI_W + DEPTH_W)'(s2_ff.prod_x[PROD_W-1:LO_W]) *
                    (HI_W + DEPTH_W)'(s2_ff.depth);
      s3_in.lo_y  = (LO_W + DEPTH_W)'(s2_ff.prod_y[LO_W-1:0]) *
                    (LO_W + DEPTH_W)'(s2_ff.depth);
      s3_in.hi_y  = (HI_W + DEPTH_W)'(s2_ff.prod_y[PROD_W-1:LO_W]) *
                    (HI_W + DEPTH_W)'(s2_ff.depth);
      s3_in.neg_x = s2_ff.neg_x;
      s3_in.neg_y = s2_ff.neg_y;
      s3_in.depth = s2_ff.depth;
      s3_in.side  = s2_ff.side;
   end

   // Stage 4: recombine the half products into the full magnitude.
   s4_type s4_ff, s4_in;

   always_comb begin
      s4_in.mag_x = (MAG_W'(s3_ff.hi_x) << LO_W) + MAG_W'(s3_ff.lo_x);
      s4_in.mag_y = (MAG_W'(s3_ff.hi_y) << LO_W) + MAG_W'(s3_ff.lo_y);
      s4_in.neg_x = s3_ff.neg_x;
      s4_in.neg_y = s3_ff.neg_y;
      s4_in.depth = s3_ff.depth;
      s4_in.side  = s3_ff.side;
   end

   // Stage 5: round toward minus infinity, saturate, blank invalid points.
   rsp_payload_type s5_ff, s5_in;
   logic            depth_ok;

   always_comb begin
      depth_ok           = s4_ff.depth != '0;
      s5_in.point_valid  = depth_ok;
      s5_in.x_q4         = depth_ok ? round_sat(s4_ff.mag_x, s4_ff.neg_x) : '0;
      s5_in.y_q4         = depth_ok ? round_sat(s4_ff.mag_y, s4_ff.neg_y) : '0;
      s5_in.z_mm         = s4_ff.depth;
      s5_in.out_blue     = depth_ok ? s4_ff.side.blue : '0;
      s5_in.out_green    = depth_ok ? s4_ff.side.green : '0;
      s5_in.out_red      = depth_ok ? s4_ff.side.red : '0;
      s5_in.end_of_frame = s4_ff.side.end_of_frame;
   end

   // Pipeline data registers.
   always_ff @(posedge clock) begin
      if (adv_s1) s1_ff <= s1_in;
      if (adv_s2) s2_ff <= s2_in;
      if (adv_s3) s3_ff <= s3_in;
      if (adv_s4) s4_ff <= s4_in;
      if (adv_s5) s5_ff <= s5_in;
   end

   assign rsp_stream.valid   = s5_valid_ff;
   assign rsp_stream.payload = s5_ff;

   // A point without depth carries no coordinates and no color.
   `DPC_ASSERT_SAME(a_invalid_blank, clock, reset,
      rsp_stream.valid && !rsp_stream.payload.point_valid,
      rsp_stream.payload.x_q4 == '0 && rsp_stream.payload.y_q4 == '0 &&
      rsp_stream.payload.out_blue == '0 && rsp_stream.payload.out_green == '0 &&
      rsp_stream.payload.out_red == '0)

   // The valid flag follows the depth of the point.
   `DPC_ASSERT_SAME(a_valid_tracks_depth, clock, reset, rsp_stream.valid,
      rsp_stream.payload.point_valid == (rsp_stream.payload.z_mm != '0))

   // An empty output register never blocks the input.
   `DPC_ASSERT_SAME(a_empty_out_ready, clock, reset, !rsp_stream.valid, req_stream.ready)

   // A full pipeline with a stalled receiver refuses new pixels.
   `DPC_ASSERT_SAME(a_full_stall, clock, reset,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff &&
      !rsp_stream.ready,
      !req_stream.ready)

endmodule
